@@ rtl/nes2hd_pkg.sv @@
// ----------------------------------------------------------------------------
// nes2hd_pkg: shared types and constants of the cartridge header decoder
// Holds the header and result types, the status codes and the size constants.
// ----------------------------------------------------------------------------
package nes2hd_pkg;

   localparam int HeaderBytes    = 16;
   localparam int PosWidth       = $clog2(HeaderBytes);
   localparam int RomWidth       = 40;
   localparam int RamWidth       = 22;
   localparam int QueueDepth     = 2;
   localparam int QueueAddrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth  = $clog2(QueueDepth + 1);

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
   localparam logic [1:0] STATUS_TRAINER   = 2'd2;

   localparam logic [1:0] MIRROR_FOUR_SCREEN = 2'd2;

   localparam logic [3:0] KIND_INES1 = 4'h0;
   localparam logic [3:0] KIND_NES2  = 4'h8;

   localparam logic [7:0] MAGIC_0 = 8'h4E;
   localparam logic [7:0] MAGIC_1 = 8'h45;
   localparam logic [7:0] MAGIC_2 = 8'h53;
   localparam logic [7:0] MAGIC_3 = 8'h1A;

   localparam logic [RamWidth-1:0] INES_PRG_RAM = RamWidth'(32'h2000);
   localparam logic [RomWidth-1:0] ROM_MAX      = {RomWidth{1'b1}};

   typedef logic [HeaderBytes-1:0][7:0] header_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [11:0]         mapper;
      logic [3:0]          submapper;
      logic [RomWidth-1:0] prg_rom_bytes;
      logic [RomWidth-1:0] chr_rom_bytes;
      logic [1:0]          mirroring;
      logic                battery;
      logic [RamWidth-1:0] prg_ram_bytes;
      logic [RamWidth-1:0] prg_nvram_bytes;
      logic [RamWidth-1:0] chr_ram_bytes;
      logic [RamWidth-1:0] chr_nvram_bytes;
      logic                size_overflow;
   } result_type;

   // Queue handshake between the collector and the decoder.
   typedef struct packed {
      logic push;
      logic full;
   } queue_wr_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } queue_rd_type;

   // Size of 64 << nibble, zero for a zero nibble.
   function automatic logic [RamWidth-1:0] shift_ram(input logic [3:0] nib);
      logic [RamWidth-1:0] v;
      v = RamWidth'(64) << nib;
      return (nib == 4'd0) ? '0 : v;
   endfunction

endpackage

@@ rtl/nes2hd_front.sv @@
// ----------------------------------------------------------------------------
// nes2hd_front: header byte collector
// Stores the first fifteen bytes and pushes the full header on the sixteenth.
// ----------------------------------------------------------------------------
module nes2hd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_header_byte,
   input  logic                   queue_full,
   output logic                   queue_push,
   output nes2hd_pkg::header_type queue_header
);
   import nes2hd_pkg::*;

   logic [PosWidth-1:0]              pos_ff, pos_in;
   logic [HeaderBytes-2:0][7:0]      store_ff, store_in;
   logic                             last_byte;
   logic                             accept;

   assign last_byte  = (pos_ff == PosWidth'(HeaderBytes - 1));
   assign req_ready  = !(last_byte && queue_full);
   assign accept     = req_valid && req_ready;
   assign queue_push = accept && last_byte;

   always_comb begin
      queue_header = {req_header_byte, store_ff};
   end

   always_comb begin
      pos_in   = pos_ff;
      store_in = store_ff;
      if (accept) begin
         pos_in = pos_ff + PosWidth'(1);
         if (!last_byte) begin
            store_in[pos_ff] = req_header_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      store_ff <= store_in;
   end

endmodule

@@ rtl/nes2hd_queue.sv @@
// ----------------------------------------------------------------------------
// nes2hd_queue: short header queue
// Two-entry FIFO of complete headers between the collector and the decoder.
// ----------------------------------------------------------------------------
module nes2hd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  nes2hd_pkg::header_type   push_header,
   input  logic                     pop,
   output nes2hd_pkg::queue_wr_type wr_status,
   output nes2hd_pkg::queue_rd_type rd_status,
   output nes2hd_pkg::header_type   head_header
);
   import nes2hd_pkg::*;

   header_type                entry_ff [QueueDepth];
   logic [QueueAddrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]  count_ff, count_in;
   logic                      do_push, do_pop;

   assign wr_status.push = push;
   assign wr_status.full = (count_ff == QueueCntWidth'(QueueDepth));
   assign rd_status.pop   = pop;
   assign rd_status.empty = (count_ff == '0);
   assign do_push = push && !wr_status.full;
   assign do_pop  = pop && !rd_status.empty;
   assign head_header = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueueAddrWidth'(QueueDepth - 1)) ? '0
                   : wr_ptr_ff + QueueAddrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueueAddrWidth'(QueueDepth - 1)) ? '0
                   : rd_ptr_ff + QueueAddrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QueueCntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_header;
      end
   end

endmodule

@@ rtl/nes2hd_back.sv @@
// ----------------------------------------------------------------------------
// nes2hd_back: header decoder and result register
// Decodes the queue head and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module nes2hd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  nes2hd_pkg::queue_rd_type rd_status,
   input  nes2hd_pkg::header_type   head_header,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output nes2hd_pkg::result_type   rsp_result
);
   import nes2hd_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;
   result_type dec;
   header_type h;
   logic [3:0] kind;
   logic       prg_ovf, chr_ovf;
   logic [RomWidth-1:0] prg_exp, chr_exp;
   logic [RomWidth+2:0] prg_wide, chr_wide;

   assign h    = head_header;
   assign kind = h[7][3:0] & 4'hC;

   // Exponent notation: (2*(L&3)+1) << (L>>2), saturated to 40 bits.
   always_comb begin
      prg_wide = (RomWidth + 3)'({h[4][1:0], 1'b1}) << h[4][7:2];
      chr_wide = (RomWidth + 3)'({h[5][1:0], 1'b1}) << h[5][7:2];
      prg_ovf  = (h[4][7:2] > 6'd40) || (prg_wide[RomWidth+2:RomWidth] != 3'd0);
      chr_ovf  = (h[5][7:2] > 6'd40) || (chr_wide[RomWidth+2:RomWidth] != 3'd0);
      prg_exp  = prg_ovf ? ROM_MAX : prg_wide[RomWidth-1:0];
      chr_exp  = chr_ovf ? ROM_MAX : chr_wide[RomWidth-1:0];
   end

   always_comb begin
      dec = '0;
      if (h[0] != MAGIC_0 || h[1] != MAGIC_1 || h[2] != MAGIC_2 || h[3] != MAGIC_3) begin
         dec.status = STATUS_BAD_MAGIC;
      end else if (h[6][2]) begin
         dec.status = STATUS_TRAINER;
      end else begin
         dec.status = STATUS_OK;
         dec.mapper = {4'd0, 4'd0, h[6][7:4]};
         if (kind == KIND_INES1 || kind == KIND_NES2) begin
            dec.mapper[7:4] = h[7][7:4];
         end
         dec.mirroring = h[6][3] ? MIRROR_FOUR_SCREEN : {1'b0, h[6][0]};
         dec.battery   = h[6][1];
         if (kind == KIND_NES2) begin
            dec.mapper[11:8] = h[8][3:0];
            dec.submapper    = h[8][7:4];
            if (h[9][3:0] == 4'hF) begin
               dec.prg_rom_bytes = prg_exp;
            end else begin
               dec.prg_rom_bytes = RomWidth'({h[9][3:0], h[4], 14'd0});
            end
            if (h[9][7:4] == 4'hF) begin
               dec.chr_rom_bytes = chr_exp;
            end else begin
               dec.chr_rom_bytes = RomWidth'({h[9][7:4], h[5], 13'd0});
            end
            dec.size_overflow   = ((h[9][3:0] == 4'hF) && prg_ovf)
                                || ((h[9][7:4] == 4'hF) && chr_ovf);
            dec.prg_ram_bytes   = shift_ram(h[10][3:0]);
            dec.prg_nvram_bytes = shift_ram(h[10][7:4]);
            dec.chr_ram_bytes   = shift_ram(h[11][3:0]);
            dec.chr_nvram_bytes = shift_ram(h[11][7:4]);
         end else begin
            // A zero PRG count stands for 256 banks.
            dec.prg_rom_bytes = (h[4] == 8'd0) ? RomWidth'({1'b1, 22'd0})
                              : RomWidth'({h[4], 14'd0});
            dec.chr_rom_bytes = RomWidth'({h[5], 13'd0});
            dec.prg_ram_bytes = INES_PRG_RAM;
         end
      end
   end

   assign pop = !rd_status.empty && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in  = 1'b1;
         result_in = dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

@@ rtl/ines_nes2_header_decoder_top.sv @@
// ----------------------------------------------------------------------------
// ines_nes2_header_decoder_top: iNES / NES 2.0 cartridge header decoder
// Takes the 16-byte header one byte per transaction and returns one decoded
// result transaction after every sixteenth byte.
// ----------------------------------------------------------------------------
// Throughput: one header byte per cycle, sustained while the queue can take each finished header.
// A complete header enters the queue at the edge that takes its sixteenth byte, and moves
// into the result register once that register is free or being emptied.
// The two-entry header queue is what lets bytes keep flowing while a result
// waits; req_ready drops only on a sixteenth byte with the queue full.
// Reset clears the byte position, the queue pointers and the result valid.
// ----------------------------------------------------------------------------
module ines_nes2_header_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_header_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [11:0]                       rsp_mapper,
   output logic [3:0]                        rsp_submapper,
   output logic [nes2hd_pkg::RomWidth-1:0]   rsp_prg_rom_bytes,
   output logic [nes2hd_pkg::RomWidth-1:0]   rsp_chr_rom_bytes,
   output logic [1:0]                        rsp_mirroring,
   output logic                              rsp_battery,
   output logic [nes2hd_pkg::RamWidth-1:0]   rsp_prg_ram_bytes,
   output logic [nes2hd_pkg::RamWidth-1:0]   rsp_prg_nvram_bytes,
   output logic [nes2hd_pkg::RamWidth-1:0]   rsp_chr_ram_bytes,
   output logic [nes2hd_pkg::RamWidth-1:0]   rsp_chr_nvram_bytes,
   output logic                              rsp_size_overflow
);
   import nes2hd_pkg::*;

   header_type   push_header;
   header_type   head_header;
   logic         queue_push;
   logic         queue_pop;
   queue_wr_type wr_status;
   queue_rd_type rd_status;
   result_type   result;

   // The front end only stores bytes; it hands a complete header to the
   // queue in the same cycle that its last byte arrives.
   nes2hd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_header_byte (req_header_byte),
      .queue_full      (wr_status.full),
      .queue_push      (queue_push),
      .queue_header    (push_header)
   );

   nes2hd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (queue_push),
      .push_header (push_header),
      .pop         (queue_pop),
      .wr_status   (wr_status),
      .rd_status   (rd_status),
      .head_header (head_header)
   );

   // The back end decodes the queue head straight into its result register, popping
   // whenever the queue holds a header and that register is free or being emptied.
   nes2hd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .rd_status   (rd_status),
      .head_header (head_header),
      .pop         (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (result)
   );

   assign rsp_status          = result.status;
   assign rsp_mapper          = result.mapper;
   assign rsp_submapper       = result.submapper;
   assign rsp_prg_rom_bytes   = result.prg_rom_bytes;
   assign rsp_chr_rom_bytes   = result.chr_rom_bytes;
   assign rsp_mirroring       = result.mirroring;
   assign rsp_battery         = result.battery;
   assign rsp_prg_ram_bytes   = result.prg_ram_bytes;
   assign rsp_prg_nvram_bytes = result.prg_nvram_bytes;
   assign rsp_chr_ram_bytes   = result.chr_ram_bytes;
   assign rsp_chr_nvram_bytes = result.chr_nvram_bytes;
   assign rsp_size_overflow   = result.size_overflow;

endmodule

@@ tb/nes2hd_header_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nes2hd_header_checker: result checker for the cartridge header decoder
// Watches both channels, rebuilds each 16-byte header from the accepted
// bytes, decodes it on its own and compares every returned field in order.
// ----------------------------------------------------------------------------
module nes2hd_header_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_header_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [1:0]                      rsp_status,
   input  logic [11:0]                     rsp_mapper,
   input  logic [3:0]                      rsp_submapper,
   input  logic [nes2hd_pkg::RomWidth-1:0] rsp_prg_rom_bytes,
   input  logic [nes2hd_pkg::RomWidth-1:0] rsp_chr_rom_bytes,
   input  logic [1:0]                      rsp_mirroring,
   input  logic                            rsp_battery,
   input  logic [nes2hd_pkg::RamWidth-1:0] rsp_prg_ram_bytes,
   input  logic [nes2hd_pkg::RamWidth-1:0] rsp_prg_nvram_bytes,
   input  logic [nes2hd_pkg::RamWidth-1:0] rsp_chr_ram_bytes,
   input  logic [nes2hd_pkg::RamWidth-1:0] rsp_chr_nvram_bytes,
   input  logic                            rsp_size_overflow,
   output int                              mismatch_count,
   output int                              pending_count,
   output int                              checked_count
);
   import nes2hd_pkg::*;

   header_type   header_bytes = '0;
   logic [3:0]   byte_index   = '0;
   result_type   pending_decodes[$];
   result_type   want_result;
   result_type   got_result;
   int           mismatches   = 0;
   int           results_seen = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
   end

   // Exponent-coded ROM size; bit RomWidth flags a saturated value.
   function automatic logic [RomWidth:0] exp_rom_size(input logic [7:0] low);
      logic [63:0] size;
      int unsigned expo;
      expo = low[7:2];
      size = 64'({low[1:0], 1'b1});
      if (expo > 40) begin
         return {1'b1, ROM_MAX};
      end
      size = size << expo;
      if (size > 64'(ROM_MAX)) begin
         return {1'b1, ROM_MAX};
      end
      return {1'b0, size[RomWidth-1:0]};
   endfunction

   function automatic logic [RamWidth-1:0] ram_from_nibble(input logic [3:0] nib);
      if (nib == 4'd0) begin
         return '0;
      end
      return RamWidth'(1) << (32'(nib) + 6);
   endfunction

   function automatic result_type decode_header(input header_type h);
      result_type           r;
      logic [3:0]           kind;
      logic [RomWidth:0]    esize;
      logic                 ovf;
      r    = '0;
      ovf  = 1'b0;
      kind = h[7][3:0] & 4'hC;
      if (h[0] != MAGIC_0 || h[1] != MAGIC_1 || h[2] != MAGIC_2 || h[3] != MAGIC_3) begin
         r.status = STATUS_BAD_MAGIC;
         return r;
      end
      if (h[6][2]) begin
         r.status = STATUS_TRAINER;
         return r;
      end
      r.status = STATUS_OK;
      r.mapper = {8'h00, h[6][7:4]};
      if (kind == KIND_INES1 || kind == KIND_NES2) begin
         r.mapper[7:4] = h[7][7:4];
      end
      if (kind == KIND_NES2) begin
         r.mapper[11:8] = h[8][3:0];
         r.submapper    = h[8][7:4];
         if (h[9][3:0] == 4'hF) begin
            esize = exp_rom_size(h[4]);
            r.prg_rom_bytes = esize[RomWidth-1:0];
            ovf = ovf | esize[RomWidth];
         end else begin
            r.prg_rom_bytes = RomWidth'({h[9][3:0], h[4]}) << 14;
         end
         if (h[9][7:4] == 4'hF) begin
            esize = exp_rom_size(h[5]);
            r.chr_rom_bytes = esize[RomWidth-1:0];
            ovf = ovf | esize[RomWidth];
         end else begin
            r.chr_rom_bytes = RomWidth'({h[9][7:4], h[5]}) << 13;
         end
         r.prg_ram_bytes   = ram_from_nibble(h[10][3:0]);
         r.prg_nvram_bytes = ram_from_nibble(h[10][7:4]);
         r.chr_ram_bytes   = ram_from_nibble(h[11][3:0]);
         r.chr_nvram_bytes = ram_from_nibble(h[11][7:4]);
      end else begin
         // In iNES 1.0 a PRG count of zero stands for 256 banks.
         r.prg_rom_bytes = (h[4] == 8'd0) ? (RomWidth'(256) << 14) : (RomWidth'(h[4]) << 14);
         r.chr_rom_bytes = RomWidth'(h[5]) << 13;
         r.prg_ram_bytes = INES_PRG_RAM;
      end
      r.mirroring     = h[6][3] ? MIRROR_FOUR_SCREEN : {1'b0, h[6][0]};
      r.battery       = h[6][1];
      r.size_overflow = ovf;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name,
                     want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_index = '0;
         pending_decodes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_result.status          = rsp_status;
            got_result.mapper          = rsp_mapper;
            got_result.submapper       = rsp_submapper;
            got_result.prg_rom_bytes   = rsp_prg_rom_bytes;
            got_result.chr_rom_bytes   = rsp_chr_rom_bytes;
            got_result.mirroring       = rsp_mirroring;
            got_result.battery         = rsp_battery;
            got_result.prg_ram_bytes   = rsp_prg_ram_bytes;
            got_result.prg_nvram_bytes = rsp_prg_nvram_bytes;
            got_result.chr_ram_bytes   = rsp_chr_ram_bytes;
            got_result.chr_nvram_bytes = rsp_chr_nvram_bytes;
            got_result.size_overflow   = rsp_size_overflow;
            if (pending_decodes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result transaction after %0d results", results_seen);
               end
            end else begin
               want_result = pending_decodes.pop_front();
               check_field("status", 64'(want_result.status), 64'(got_result.status));
               check_field("mapper", 64'(want_result.mapper), 64'(got_result.mapper));
               check_field("submapper", 64'(want_result.submapper),
                           64'(got_result.submapper));
               check_field("prg_rom_bytes", 64'(want_result.prg_rom_bytes),
                           64'(got_result.prg_rom_bytes));
               check_field("chr_rom_bytes", 64'(want_result.chr_rom_bytes),
                           64'(got_result.chr_rom_bytes));
               check_field("mirroring", 64'(want_result.mirroring),
                           64'(got_result.mirroring));
               check_field("battery", 64'(want_result.battery), 64'(got_result.battery));
               check_field("prg_ram_bytes", 64'(want_result.prg_ram_bytes),
                           64'(got_result.prg_ram_bytes));
               check_field("prg_nvram_bytes", 64'(want_result.prg_nvram_bytes),
                           64'(got_result.prg_nvram_bytes));
               check_field("chr_ram_bytes", 64'(want_result.chr_ram_bytes),
                           64'(got_result.chr_ram_bytes));
               check_field("chr_nvram_bytes", 64'(want_result.chr_nvram_bytes),
                           64'(got_result.chr_nvram_bytes));
               check_field("size_overflow", 64'(want_result.size_overflow),
                           64'(got_result.size_overflow));
               results_seen++;
            end
         end
         if (req_valid && req_ready) begin
            header_bytes[byte_index] = req_header_byte;
            if (byte_index == 4'd15) begin
               pending_decodes.push_back(decode_header(header_bytes));
            end
            byte_index = byte_index + 4'd1;
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= pending_decodes.size();
      checked_count  <= results_seen;
   end

endmodule

@@ tb/ines_nes2_header_decoder_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ines_nes2_header_decoder_top_tb: testbench of the cartridge header decoder
// Streams one directed header and a few dozen random headers of every
// format through the decoder under random sender gaps and receiver stalls,
// while a checker module predicts and compares each decoded result.
// ----------------------------------------------------------------------------
module ines_nes2_header_decoder_top_tb;
   import nes2hd_pkg::*;

   // Header flavors that the random part of the run draws from.
   typedef enum int {
      HDR_INES1,
      HDR_NES2,
      HDR_NES2_EXP,
      HDR_ODD_KIND,
      HDR_TRAINER,
      HDR_BAD_MAGIC,
      HDR_NOISE,
      HDR_MODES
   } header_mode_type;

   // Stall patterns of the result receiver.
   typedef enum int {
      RDY_ALWAYS,
      RDY_MOSTLY,
      RDY_RARELY,
      RDY_TOGGLE
   } ready_mode_type;

   localparam int RandomHeaders = 41;
   localparam int PressureAt    = 20;
   localparam int CycleLimit    = 200000;
   localparam int DrainCycles   = 20;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [7:0]          req_header_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [1:0]          rsp_status;
   logic [11:0]         rsp_mapper;
   logic [3:0]          rsp_submapper;
   logic [RomWidth-1:0] rsp_prg_rom_bytes;
   logic [RomWidth-1:0] rsp_chr_rom_bytes;
   logic [1:0]          rsp_mirroring;
   logic                rsp_battery;
   logic [RamWidth-1:0] rsp_prg_ram_bytes;
   logic [RamWidth-1:0] rsp_prg_nvram_bytes;
   logic [RamWidth-1:0] rsp_chr_ram_bytes;
   logic [RamWidth-1:0] rsp_chr_nvram_bytes;
   logic                rsp_size_overflow;

   int             mismatch_count;
   int             pending_count;
   int             checked_count;
   int unsigned    cycle_count  = 0;
   int             burst_left   = 0;
   int             bytes_sent   = 0;
   int             mode_count[HDR_MODES];
   ready_mode_type ready_mode   = RDY_ALWAYS;
   int             ready_phase  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ines_nes2_header_decoder_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_header_byte     (req_header_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_mapper          (rsp_mapper),
      .rsp_submapper       (rsp_submapper),
      .rsp_prg_rom_bytes   (rsp_prg_rom_bytes),
      .rsp_chr_rom_bytes   (rsp_chr_rom_bytes),
      .rsp_mirroring       (rsp_mirroring),
      .rsp_battery         (rsp_battery),
      .rsp_prg_ram_bytes   (rsp_prg_ram_bytes),
      .rsp_prg_nvram_bytes (rsp_prg_nvram_bytes),
      .rsp_chr_ram_bytes   (rsp_chr_ram_bytes),
      .rsp_chr_nvram_bytes (rsp_chr_nvram_bytes),
      .rsp_size_overflow   (rsp_size_overflow)
   );

   // The checker sits on the same wires as the decoder and only observes.
   nes2hd_header_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_header_byte     (req_header_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_mapper          (rsp_mapper),
      .rsp_submapper       (rsp_submapper),
      .rsp_prg_rom_bytes   (rsp_prg_rom_bytes),
      .rsp_chr_rom_bytes   (rsp_chr_rom_bytes),
      .rsp_mirroring       (rsp_mirroring),
      .rsp_battery         (rsp_battery),
      .rsp_prg_ram_bytes   (rsp_prg_ram_bytes),
      .rsp_prg_nvram_bytes (rsp_prg_nvram_bytes),
      .rsp_chr_ram_bytes   (rsp_chr_ram_bytes),
      .rsp_chr_nvram_bytes (rsp_chr_nvram_bytes),
      .rsp_size_overflow   (rsp_size_overflow),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .checked_count       (checked_count)
   );

   // The run is far shorter than this limit; reaching it means a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
                  pending_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver picks a new stall pattern whenever the current one runs out. The
   // always-ready stretches give periods of full throughput, while the rarely
   // ready ones let the header queue fill up and push back on the sender.
   always @(posedge clock) begin
      if (ready_phase == 0) begin
         ready_mode  = ready_mode_type'($urandom_range(RDY_ALWAYS, RDY_TOGGLE));
         ready_phase = $urandom_range(8, 80);
      end
      ready_phase = ready_phase - 1;
      case (ready_mode)
         RDY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RDY_MOSTLY: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         RDY_RARELY: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= ready_phase[2];
         end
      endcase
   end

   // Builds one random header of the given flavor. Well-formed headers keep
   // the magic and clear the trainer bit so that the decode gets past its
   // early checks; the rest of the content stays random.
   function automatic header_type make_header(input header_mode_type mode);
      header_type h;
      int         k;
      for (k = 0; k < HeaderBytes; k++) begin
         h[k] = 8'($urandom);
      end
      h[0]    = MAGIC_0;
      h[1]    = MAGIC_1;
      h[2]    = MAGIC_2;
      h[3]    = MAGIC_3;
      h[6][2] = 1'b0;
      case (mode)
         HDR_INES1: begin
            h[7][3:2] = 2'b00;
            if ($urandom_range(0, 3) == 0) begin
               h[4] = 8'h00;
            end
         end
         HDR_NES2: begin
            h[7][3:2] = 2'b10;
            // Keep the plain bank-count form here; exponent sizes get their
            // own flavor below.
            if (h[9][3:0] == 4'hF) begin
               h[9][3:0] = 4'($urandom_range(0, 14));
            end
            if (h[9][7:4] == 4'hF) begin
               h[9][7:4] = 4'($urandom_range(0, 14));
            end
            if ($urandom_range(0, 5) == 0) begin
               h[4]      = 8'h00;
               h[9][3:0] = 4'h0;
            end
            for (k = 10; k < 12; k++) begin
               if ($urandom_range(0, 3) == 0) begin
                  h[k][3:0] = 4'h0;
               end
               if ($urandom_range(0, 3) == 0) begin
                  h[k][7:4] = 4'h0;
               end
            end
         end
         HDR_NES2_EXP: begin
            h[7][3:2] = 2'b10;
            k = $urandom_range(1, 3);
            if (k[0]) begin
               h[9][3:0] = 4'hF;
               if ($urandom_range(0, 1) == 0) begin
                  h[4][7:2] = 6'($urandom_range(0, 40));
               end
            end
            if (k[1]) begin
               h[9][7:4] = 4'hF;
               if ($urandom_range(0, 1) == 0) begin
                  h[5][7:2] = 6'($urandom_range(0, 40));
               end
            end
         end
         HDR_ODD_KIND: begin
            h[7][3:2] = ($urandom_range(0, 1) == 0) ? 2'b01 : 2'b11;
         end
         HDR_TRAINER: begin
            h[6][2] = 1'b1;
         end
         HDR_BAD_MAGIC: begin
            k = $urandom_range(0, 3);
            h[k] = h[k] ^ 8'($urandom_range(1, 255));
         end
         default: begin
            for (k = 0; k < HeaderBytes; k++) begin
               h[k] = 8'($urandom);
            end
         end
      endcase
      return h;
   endfunction

   // Offers one byte and waits for its transaction. A new burst starts with
   // a gap unless the drawn gap is zero, so gaps land on every byte position.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left      = burst_left - 1;
      req_valid       <= 1'b1;
      req_header_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_header(input header_type h);
      int k;
      for (k = 0; k < HeaderBytes; k++) begin
         send_byte(h[k]);
      end
   endtask

   initial begin
      header_type      h;
      header_mode_type mode;
      int              n;
      int              pick;

      for (n = 0; n < HDR_MODES; n++) begin
         mode_count[n] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed header: NES 2.0 with a zero PRG bank count, a saturating
      // exponent-coded CHR size, all mapper and submapper bits set, four-screen
      // mirroring with battery, and both byte extremes in the padding.
      h[0]  = MAGIC_0;
      h[1]  = MAGIC_1;
      h[2]  = MAGIC_2;
      h[3]  = MAGIC_3;
      h[4]  = 8'h00;
      h[5]  = 8'hFF;
      h[6]  = 8'hFB;
      h[7]  = 8'hF8;
      h[8]  = 8'hFF;
      h[9]  = 8'hF0;
      h[10] = 8'hF1;
      h[11] = 8'h0F;
      h[12] = 8'h00;
      h[13] = 8'hFF;
      h[14] = 8'h00;
      h[15] = 8'hFF;
      send_header(h);
      mode_count[HDR_NES2_EXP]++;

      for (n = 0; n < RandomHeaders; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            mode = HDR_INES1;
         end else if (pick < 42) begin
            mode = HDR_NES2;
         end else if (pick < 62) begin
            mode = HDR_NES2_EXP;
         end else if (pick < 70) begin
            mode = HDR_ODD_KIND;
         end else if (pick < 78) begin
            mode = HDR_TRAINER;
         end else if (pick < 90) begin
            mode = HDR_BAD_MAGIC;
         end else begin
            mode = HDR_NOISE;
         end
         mode_count[mode]++;
         send_header(make_header(mode));

         // Once in the run the sender holds off until the decoder has
         // returned everything, so the next header starts on an empty pipe.
         if (n == PressureAt) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d bytes: %0d iNES 1.0, %0d NES 2.0, %0d exponent-size, %0d odd-format,",
               bytes_sent, mode_count[HDR_INES1], mode_count[HDR_NES2],
               mode_count[HDR_NES2_EXP], mode_count[HDR_ODD_KIND]);
      $display("%0d trainer, %0d bad-magic, %0d noise headers; %0d results checked.",
               mode_count[HDR_TRAINER], mode_count[HDR_BAD_MAGIC], mode_count[HDR_NOISE],
               checked_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results never returned", mismatch_count,
                  pending_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/nes2hd_pkg.sv
rtl/nes2hd_front.sv
rtl/nes2hd_queue.sv
rtl/nes2hd_back.sv
rtl/ines_nes2_header_decoder_top.sv
tb/nes2hd_header_checker.sv
tb/ines_nes2_header_decoder_top_tb.sv
